// ----- rtl/battery_level_bargraph_top_assert.svh -----
// Assertion macros for the battery level bargraph meter.
// Used by battery_level_bargraph_top; expects clk and rst_n in scope.
`ifndef BATTERY_LEVEL_BARGRAPH_TOP_ASSERT_SVH
`define BATTERY_LEVEL_BARGRAPH_TOP_ASSERT_SVH

// Condition in the same cycle.
`define BBG_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Condition in the following cycle.
`define BBG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/bbg_pkg.sv -----
// Shared types and constants for the battery level bargraph meter.
// No dependencies; used by every module of the block.
package bbg_pkg;

    localparam int SAMPLE_W             = 8;
    localparam int LOW_W                = 8;
    localparam int STEP_W               = 5;
    localparam int CFG_DATA_W           = 8;
    localparam int CFG_IDX_W            = 1;
    localparam int THRESH_COUNT         = 8;
    // Highest threshold is 255 + 31 * 7 = 472.
    localparam int LEVEL_W              = 9;
    localparam int IN_TDATA_W           = 8;
    localparam int OUT_TDATA_W          = 24;

    localparam int WINDOW_DEPTH_DEFAULT = 8;
    localparam int RING_RESET           = 185;

    localparam logic [LOW_W-1:0]  LOW_THRESHOLD_RESET = 8'd153;
    localparam logic [STEP_W-1:0] STEP_SIZE_RESET     = 5'd4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LOW_THRESHOLD = 1'b0,
        REG_STEP_SIZE     = 1'b1
    } bbg_reg_idx_t;

    // Packed so that average lands in the lowest bits of tdata.
    typedef struct packed {
        logic                low_battery;
        logic [THRESH_COUNT-1:0] bar_pattern;
        logic [SAMPLE_W-1:0] average;
    } bbg_result_t;

endpackage

// ----- rtl/battery_level_bargraph_top.sv -----
// Top level of the battery level bargraph meter.
// Depends on bbg_pkg, bbg_window, bbg_average, bbg_ladder and the assert header.
//
// Usage:
//   Samples arrive on the s_ channel; tdata carries the 8-bit sample. Each
//   transfer in produces exactly one transfer out on the m_ channel, whose
//   tdata holds average, bar pattern and low-battery flag.
//   The window keeps the last WINDOW_DEPTH samples in a shift line with a
//   running sum, so each sample costs one add and one subtract.
//   The pipeline has three registered stages: window sum, average (one
//   reciprocal multiply) and threshold ladder with the output register.
//   A result moves from the sum register through the average register to
//   the output register, where it shows on m_tvalid and m_tdata.
//   Throughput is one sample per cycle while the receiver keeps m_tready
//   high; every stage advances whenever the stage after it is free.
//   When the receiver stalls, the result holds on m_tdata and the stages
//   behind it keep filling; s_tready drops only once all three are full.
//   Reset empties the pipeline, fills every window entry with 185 and
//   loads the threshold registers with their defaults (low 153, step 4).
//   Configuration writes are taken on any cycle at which cfg_wr_en is high
//   and should only be issued while no sample is in flight.
module battery_level_bargraph_top #(
    parameter int WINDOW_DEPTH = bbg_pkg::WINDOW_DEPTH_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // Sample stream in.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [bbg_pkg::IN_TDATA_W-1:0]    s_tdata,   // [7:0] sample
    // Result stream out.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [bbg_pkg::OUT_TDATA_W-1:0]   m_tdata,   // [7:0] average, [15:8] bar_pattern,
                                                         // [16] low_battery, [23:17] zero
    // Register write port.
    input  logic                              cfg_wr_en,
    input  logic [bbg_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  logic [bbg_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    localparam int SUM_W    = $clog2(255 * WINDOW_DEPTH + 1);
    localparam int RESULT_W = $bits(bbg_pkg::bbg_result_t);

    logic                         sum_valid_reg;
    logic                         avg_valid_reg;
    logic                         out_valid_reg;
    logic                         out_free;
    logic                         avg_free;
    logic                         sum_free;
    logic                         avg_load;
    logic                         out_load;
    logic                         accept;
    logic [SUM_W-1:0]             window_sum;
    logic [bbg_pkg::SAMPLE_W-1:0] average;
    bbg_pkg::bbg_result_t         result;
    logic [bbg_pkg::LOW_W-1:0]    low_threshold_reg;
    logic [bbg_pkg::STEP_W-1:0]   step_size_reg;

    // A stage can take new data when it is empty or its content moves on
    // in the same cycle.
    assign out_free = !out_valid_reg || m_tready;
    assign out_load = avg_valid_reg && out_free;
    assign avg_free = !avg_valid_reg || out_load;
    assign avg_load = sum_valid_reg && avg_free;
    assign sum_free = !sum_valid_reg || avg_load;
    assign s_tready = sum_free;
    assign accept   = s_tvalid && sum_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_valid_reg <= 1'b0;
            avg_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (sum_free)
            begin
                sum_valid_reg <= s_tvalid;
            end
            if (avg_free)
            begin
                avg_valid_reg <= sum_valid_reg;
            end
            if (out_free)
            begin
                out_valid_reg <= avg_valid_reg;
            end
        end
    end

    // Threshold registers; the step size keeps only its low five bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_threshold_reg <= bbg_pkg::LOW_THRESHOLD_RESET;
            step_size_reg     <= bbg_pkg::STEP_SIZE_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (bbg_pkg::bbg_reg_idx_t'(cfg_addr))
                bbg_pkg::REG_LOW_THRESHOLD:
                begin
                    low_threshold_reg <= cfg_wdata[bbg_pkg::LOW_W-1:0];
                end
                bbg_pkg::REG_STEP_SIZE:
                begin
                    step_size_reg <= cfg_wdata[bbg_pkg::STEP_W-1:0];
                end
            endcase
        end
    end

    bbg_window #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .SUM_W        (SUM_W)
    ) u_window (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (accept),
        .sample (s_tdata[bbg_pkg::SAMPLE_W-1:0]),
        .sum    (window_sum)
    );

    bbg_average #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .SUM_W        (SUM_W)
    ) u_average (
        .clk     (clk),
        .load    (avg_load),
        .sum     (window_sum),
        .average (average)
    );

    bbg_ladder u_ladder (
        .clk           (clk),
        .load          (out_load),
        .average       (average),
        .low_threshold (low_threshold_reg),
        .step_size     (step_size_reg),
        .result        (result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(bbg_pkg::OUT_TDATA_W - RESULT_W){1'b0}}, result};

    `include "battery_level_bargraph_top_assert.svh"

    `BBG_ASSERT_SAME(a_low_full_bar, m_tvalid && m_tdata[16], m_tdata[15:8] == 8'hFF,
        "low battery reported without a full bar pattern")
    `BBG_ASSERT_SAME(a_bar_thermometer, m_tvalid,
        (~m_tdata[15:8] & (~m_tdata[15:8] + 8'd1)) == 8'd0,
        "bar pattern is not a run of ones from the top")
    `BBG_ASSERT_NEXT(a_accept_fills_sum, accept, sum_valid_reg,
        "accepted sample did not reach the sum stage")
    `BBG_ASSERT_SAME(a_full_stalls_input,
        sum_valid_reg && avg_valid_reg && out_valid_reg && !m_tready, !s_tready,
        "input taken while every stage is full and the output stalls")

endmodule

// ----- rtl/bbg_window.sv -----
// Sample window of the bargraph meter: a shift line of the most recent samples
// and a running sum over it. Depends on bbg_pkg.
module bbg_window #(
    parameter int WINDOW_DEPTH = bbg_pkg::WINDOW_DEPTH_DEFAULT,
    parameter int SUM_W        = $clog2(255 * WINDOW_DEPTH + 1)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         load,
    input  logic [bbg_pkg::SAMPLE_W-1:0] sample,
    output logic [SUM_W-1:0]             sum
);

    localparam logic [bbg_pkg::SAMPLE_W-1:0] TAP_RESET =
        bbg_pkg::SAMPLE_W'(bbg_pkg::RING_RESET);
    localparam logic [SUM_W-1:0] SUM_RESET = SUM_W'(bbg_pkg::RING_RESET * WINDOW_DEPTH);

    logic [bbg_pkg::SAMPLE_W-1:0] taps_reg [WINDOW_DEPTH];
    logic [SUM_W-1:0]             sum_reg;
    logic [SUM_W-1:0]             sum_next;

    // The oldest sample leaves the window as the new one enters. The result
    // always lies in range, so modular arithmetic at SUM_W bits is exact.
    assign sum_next = sum_reg + SUM_W'(sample) - SUM_W'(taps_reg[WINDOW_DEPTH-1]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WINDOW_DEPTH; i++)
            begin
                taps_reg[i] <= TAP_RESET;
            end
            sum_reg <= SUM_RESET;
        end
        else if (load)
        begin
            taps_reg[0] <= sample;
            for (int i = 1; i < WINDOW_DEPTH; i++)
            begin
                taps_reg[i] <= taps_reg[i-1];
            end
            sum_reg <= sum_next;
        end
    end

    assign sum = sum_reg;

endmodule

// ----- rtl/bbg_average.sv -----
// Average stage of the bargraph meter: divides the window sum by the window
// depth with an exact reciprocal multiply and registers it. Depends on bbg_pkg.
module bbg_average #(
    parameter int WINDOW_DEPTH = bbg_pkg::WINDOW_DEPTH_DEFAULT,
    parameter int SUM_W        = $clog2(255 * WINDOW_DEPTH + 1)
) (
    input  logic                         clk,
    input  logic                         load,
    input  logic [SUM_W-1:0]             sum,
    output logic [bbg_pkg::SAMPLE_W-1:0] average
);

    // With shift = SUM_W + ceil(log2 depth) and the reciprocal rounded up,
    // the product's upper bits equal floor(sum / depth) for every sum.
    localparam int DEPTH_LOG   = $clog2(WINDOW_DEPTH);
    localparam int RECIP_SHIFT = SUM_W + DEPTH_LOG;
    localparam int RECIP_W     = SUM_W + 1;
    localparam int PROD_W      = SUM_W + RECIP_W;
    localparam longint RECIP_INT =
        ((longint'(1) << RECIP_SHIFT) + WINDOW_DEPTH - 1) / WINDOW_DEPTH;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_INT);

    logic [PROD_W-1:0]            product;
    logic [bbg_pkg::SAMPLE_W-1:0] average_reg;

    assign product = PROD_W'(sum) * PROD_W'(RECIP);

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            average_reg <= product[RECIP_SHIFT +: bbg_pkg::SAMPLE_W];
        end
    end

    assign average = average_reg;

endmodule

// ----- rtl/bbg_ladder.sv -----
// Threshold ladder of the bargraph meter: compares the average with eight
// evenly spaced levels and registers the result item. Depends on bbg_pkg.
module bbg_ladder (
    input  logic                         clk,
    input  logic                         load,
    input  logic [bbg_pkg::SAMPLE_W-1:0] average,
    input  logic [bbg_pkg::LOW_W-1:0]    low_threshold,
    input  logic [bbg_pkg::STEP_W-1:0]   step_size,
    output bbg_pkg::bbg_result_t         result
);

    logic [bbg_pkg::THRESH_COUNT-1:0] exceeded;
    bbg_pkg::bbg_result_t             result_next;
    bbg_pkg::bbg_result_t             result_reg;

    for (genvar k = 0; k < bbg_pkg::THRESH_COUNT; k++)
    begin : g_level
        logic [bbg_pkg::LEVEL_W-1:0] level;
        assign level = bbg_pkg::LEVEL_W'(low_threshold)
                     + bbg_pkg::LEVEL_W'(step_size) * bbg_pkg::LEVEL_W'(k);
        assign exceeded[k] = bbg_pkg::LEVEL_W'(average) > level;
    end

    // Levels never decrease with k, so the exceeded levels form a run from
    // the bottom. Inverting them therefore leaves exactly the bits of the levels
    // not exceeded set, the same as 0xFF shifted left by their count.
    always_comb
    begin
        result_next.average     = average;
        result_next.bar_pattern = ~exceeded;
        result_next.low_battery = ~exceeded[0];
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

// ----- tb/battery_level_bargraph_top_tb.sv -----
// Self-checking testbench for the battery level bargraph meter.
// Depends on bbg_pkg and battery_level_bargraph_top; holds its own scoreboard class.
`timescale 1ns / 1ps

// Keeps a private copy of the sample window and the threshold registers,
// predicts one result per accepted sample and checks results in order.
class bargraph_scoreboard;
    logic [7:0]             window [8];
    int unsigned            wr_ptr;
    logic [7:0]             low_level;
    logic [4:0]             step;
    bbg_pkg::bbg_result_t   expected_q [$];
    int unsigned            errors;

    function new();
        foreach (window[i])
        begin
            window[i] = 8'(bbg_pkg::RING_RESET);
        end
        wr_ptr    = 0;
        low_level = bbg_pkg::LOW_THRESHOLD_RESET;
        step      = bbg_pkg::STEP_SIZE_RESET;
        errors    = 0;
    endfunction

    task report_mismatch(input string msg);
        errors++;
        $display("MISMATCH at %0t ns: %s", $time, msg);
    endtask

    function void write_reg(input bbg_pkg::bbg_reg_idx_t idx, input logic [7:0] data);
        case (idx)
            bbg_pkg::REG_LOW_THRESHOLD: low_level = data;
            bbg_pkg::REG_STEP_SIZE:     step      = data[4:0];
            default: ;
        endcase
    endfunction

    function int unsigned pending();
        return expected_q.size();
    endfunction

    // Called for every accepted sample: updates the window and queues the result.
    function void note_sample(input logic [7:0] value);
        int unsigned          total;
        int unsigned          passed;
        logic [7:0]           avg;
        bbg_pkg::bbg_result_t res;
        total  = 0;
        passed = 0;
        window[wr_ptr] = value;
        wr_ptr = (wr_ptr + 1) % 8;
        foreach (window[i])
        begin
            total += window[i];
        end
        avg = 8'(total >> 3);
        // Thresholds are compared at full width, so levels above 255 never pass.
        for (int k = 0; k < 8; k++)
        begin
            if (int'(avg) > int'(low_level) + int'(step) * k)
            begin
                passed++;
            end
        end
        res.average     = avg;
        res.bar_pattern = 8'hFF << passed;
        res.low_battery = (passed == 0);
        expected_q.push_back(res);
    endfunction

    // Called for every accepted result.
    task check_result(input logic [bbg_pkg::OUT_TDATA_W-1:0] tdata);
        bbg_pkg::bbg_result_t got;
        bbg_pkg::bbg_result_t want;
        got = tdata[16:0];
        if (expected_q.size() == 0)
        begin
            report_mismatch($sformatf("result 0x%06h with nothing expected", tdata));
        end
        else
        begin
            want = expected_q.pop_front();
            if (got.average !== want.average)
            begin
                report_mismatch($sformatf("average got %0d want %0d",
                                          got.average, want.average));
            end
            if (got.bar_pattern !== want.bar_pattern)
            begin
                report_mismatch($sformatf("bar_pattern got 0x%02h want 0x%02h (avg %0d)",
                                          got.bar_pattern, want.bar_pattern, want.average));
            end
            if (got.low_battery !== want.low_battery)
            begin
                report_mismatch($sformatf("low_battery got %b want %b (avg %0d)",
                                          got.low_battery, want.low_battery, want.average));
            end
            if (tdata[bbg_pkg::OUT_TDATA_W-1:17] !== '0)
            begin
                report_mismatch($sformatf("padding bits of tdata not zero: 0x%06h", tdata));
            end
        end
    endtask
endclass

module battery_level_bargraph_top_tb;

    // Ten random phases of 165 samples, each under its own threshold setting.
    localparam int PHASES         = 10;
    localparam int PHASE_SAMPLES  = 165;

    logic                            clk;
    logic                            rst_n;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [bbg_pkg::IN_TDATA_W-1:0]  s_tdata;    // [7:0] sample
    logic                            m_tvalid;
    logic                            m_tready;
    logic [bbg_pkg::OUT_TDATA_W-1:0] m_tdata;    // [7:0] average, [15:8] bar_pattern,
                                                 // [16] low_battery
    logic                            cfg_wr_en;
    logic [bbg_pkg::CFG_IDX_W-1:0]   cfg_addr;
    logic [bbg_pkg::CFG_DATA_W-1:0]  cfg_wdata;

    // Threshold settings per phase. Phases 7 and 8 draw random values instead.
    // Step zero collapses all thresholds onto the low level; low 255 with a
    // large step puts every threshold out of reach of the average.
    logic [7:0] low_tbl  [PHASES] = '{8'd153, 8'd0, 8'd255, 8'd255, 8'd0,
                                      8'd100, 8'd200, 8'd0, 8'd0, 8'd40};
    logic [4:0] step_tbl [PHASES] = '{5'd4, 5'd0, 5'd31, 5'd0, 5'd31,
                                      5'd1, 5'd7, 5'd0, 5'd0, 5'd3};

    bargraph_scoreboard sb;
    bit                 s_taken;
    bit                 gaps_on;
    bit                 stalls_on;

    battery_level_bargraph_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    // Monitor. Both sides are sampled at the rising edge, where the block's
    // registers still hold their old values, so each transfer is seen exactly
    // once. The driver looks at s_taken on the following falling edge.
    always @(posedge clk)
    begin
        s_taken = rst_n && s_tvalid && s_tready;
        if (s_taken)
        begin
            sb.note_sample(s_tdata[7:0]);
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            sb.check_result(m_tdata);
        end
    end

    // Receiver. While stalls are enabled, m_tready drops in bursts of random length,
    // separated by ready stretches of varying length.
    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stalls_on && $urandom_range(0, 5) == 0)
            begin
                m_tready = 1'b0;
                repeat ($urandom_range(1, 10)) @(negedge clk);
            end
            m_tready = 1'b1;
            repeat ($urandom_range(0, 15)) @(negedge clk);
        end
    end

    // Hard limit on the run.
    initial
    begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // Offers one sample and holds it until the transfer completes. Must be
    // entered at a falling edge; returns at the falling edge after the transfer
    // with s_tvalid still high, so back-to-back samples follow with no gap.
    task send_sample(input logic [7:0] value);
        if (gaps_on && $urandom_range(0, 4) == 0)
        begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = value;
        do
        begin
            @(negedge clk);
        end
        while (!s_taken);
    endtask

    // Stops sending and waits until every queued result has been checked, which
    // leaves the three-stage pipeline empty; it then idles before returning.
    task drain_results();
        s_tvalid = 1'b0;
        while (sb.pending() != 0)
        begin
            @(negedge clk);
        end
        repeat (6) @(negedge clk);
    endtask

    // One-cycle register write; only called while the block is idle.
    task write_reg(input bbg_pkg::bbg_reg_idx_t idx, input logic [7:0] data);
        cfg_wr_en = 1'b1;
        cfg_addr  = idx;
        cfg_wdata = data;
        @(negedge clk);
        cfg_wr_en = 1'b0;
        sb.write_reg(idx, data);
    endtask

    // Mostly samples scattered around a center so that the average walks
    // across the threshold ladder; the rest is uniform noise over the field.
    function automatic logic [7:0] pick_sample(input int center);
        int v;
        if ($urandom_range(0, 9) < 3)
        begin
            return 8'($urandom_range(0, 255));
        end
        v = center + int'($urandom_range(0, 20)) - 10;
        if (v < 0)
        begin
            v = 0;
        end
        if (v > 255)
        begin
            v = 255;
        end
        return 8'(v);
    endfunction

    initial
    begin
        logic [7:0] low_val;
        logic [4:0] step_val;
        int         center;

        sb        = new();
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_wr_en = 1'b0;
        cfg_addr  = bbg_pkg::REG_LOW_THRESHOLD;
        cfg_wdata = '0;
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed part under the reset thresholds (low 153, step 4): field
        // extremes and alternating bit patterns, then a window full of 255 so
        // that every threshold is passed and the pattern empties, then a
        // window full of zeros for the low-battery case, and finally a window
        // of 153 on the low threshold, then 161 and 169 nudging the average past it.
        send_sample(8'd255);
        send_sample(8'd0);
        send_sample(8'h55);
        send_sample(8'hAA);
        repeat (8) send_sample(8'd255);
        repeat (8) send_sample(8'd0);
        repeat (8) send_sample(8'd153);
        send_sample(8'd161);
        send_sample(8'd169);
        drain_results();

        for (int p = 0; p < PHASES; p++)
        begin
            // Registers change only with the pipeline empty.
            if (p == 7 || p == 8)
            begin
                low_val  = 8'($urandom_range(0, 255));
                step_val = 5'($urandom_range(0, 31));
            end
            else
            begin
                low_val  = low_tbl[p];
                step_val = step_tbl[p];
            end
            write_reg(bbg_pkg::REG_LOW_THRESHOLD, low_val);
            // The upper three data bits are junk; the block keeps only five.
            write_reg(bbg_pkg::REG_STEP_SIZE, {3'($urandom_range(0, 7)), step_val});

            // The last phase runs with no gaps on either side.
            gaps_on   = (p != PHASES - 1);
            stalls_on = (p != PHASES - 1);
            center    = 0;

            for (int i = 0; i < PHASE_SAMPLES; i++)
            begin
                if (i % 40 == 0)
                begin
                    center = int'(low_val) + int'(step_val) * int'($urandom_range(0, 8))
                             + int'($urandom_range(0, 2));
                end
                // Once in the run the sender holds off until every result is back.
                if (p == 2 && i == 80)
                begin
                    drain_results();
                end
                send_sample(pick_sample(center));
            end
            drain_results();
        end

        if (sb.errors == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule

// ----- battery_level_bargraph_top.f -----
+incdir+rtl
rtl/bbg_pkg.sv
rtl/bbg_window.sv
rtl/bbg_average.sv
rtl/bbg_ladder.sv
rtl/battery_level_bargraph_top.sv
tb/battery_level_bargraph_top_tb.sv
